FILE: design/ifq_pkg.sv
// Shared types and constants for the IEEE float to quadruple format converter.
package ifq_pkg;

    localparam int unsigned ExpW = 12;
    localparam int unsigned FracW = 64;
    localparam int unsigned ShiftW = 6;
    localparam int unsigned KW = 7;
    localparam int unsigned LW = 5;
    localparam int unsigned LimW = 11;
    localparam int unsigned CfgDataW = 7;

    localparam logic [12:0] BiasSingle = 13'd127;
    localparam logic [12:0] BiasDouble = 13'd1023;
    localparam logic [LW-1:0] EwSingle = 5'd8;
    localparam logic [LW-1:0] EwDouble = 5'd11;
    localparam logic [KW-1:0] KReset = 7'd32;
    localparam logic [LW-1:0] LReset = 5'd9;

    typedef enum logic {
        CFG_SIGNIFICAND_BITS = 1'b0,
        CFG_EXPONENT_BITS    = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic              sign;
        logic              zero;
        logic [FracW-1:0]  frac;
        logic [ExpW-1:0]   raw;
        logic [LimW-1:0]   lim;
        logic              clamp;
        logic [ShiftW-1:0] shamt;
    } t_unpacked;

    typedef struct packed {
        logic              sign;
        logic              zero;
        logic              ovf;
        logic              unf;
        logic [ExpW-1:0]   exp;
        logic [FracW-1:0]  coarse;
        logic [ShiftW-1:0] shamt;
    } t_ranged;

endpackage

FILE: design/ieee_float_to_quad_format_core.sv
// Top level of the IEEE float to significand, exponent, zero and sign converter.

// Converts one single or double precision pattern per cycle into a K-bit significand,
// a signed exponent, a zero flag and a sign. A transfer taken with i_start passes
// through three register stages (unpack, range check with coarse shift, fine shift and
// select) and appears on the result ports for one cycle, marked by o_valid.
// o_busy is always low, so a new item may enter in every cycle.
// Results cannot be held off. Configuration writes take effect at once and belong in
// idle periods.
module ieee_float_to_quad_format_core #(
    parameter int unsigned MAX_SIGNIFICAND_BITS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic                               i_kind,
    input  logic [63:0]                        i_value_bits,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_addr,
    input  logic [ifq_pkg::CfgDataW-1:0]       i_cfg_data,
    output logic                               o_valid,
    output logic [MAX_SIGNIFICAND_BITS-1:0]    o_significand,
    output logic signed [ifq_pkg::ExpW-1:0]    o_exponent,
    output logic                               o_is_zero,
    output logic                               o_sign
);

    localparam logic [ifq_pkg::KW-1:0] KMax = ifq_pkg::KW'(MAX_SIGNIFICAND_BITS);

    logic [ifq_pkg::KW-1:0] r_sig_bits;
    logic [ifq_pkg::LW-1:0] r_exp_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig_bits <= ifq_pkg::KReset;
            r_exp_bits <= ifq_pkg::LReset;
        end else if (i_cfg_we) begin
            unique case (ifq_pkg::t_cfg_reg'(i_cfg_addr))
                ifq_pkg::CFG_SIGNIFICAND_BITS: r_sig_bits <= i_cfg_data;
                ifq_pkg::CFG_EXPONENT_BITS:    r_exp_bits <= i_cfg_data[ifq_pkg::LW-1:0];
                default: ;
            endcase
        end
    end

    // Stage 1: unpack.
    ifq_pkg::t_unpacked n_s1;
    ifq_pkg::t_unpacked r_s1;
    logic               r_v1;
    logic [10:0]        bexp;
    logic               mant_zero;
    logic [12:0]        bias;
    logic [ifq_pkg::LW-1:0] ewidth;
    logic [ifq_pkg::KW-1:0] k_eff;
    logic [12:0]        raw_wide;

    always_comb begin
        if (r_sig_bits == '0) begin
            k_eff = ifq_pkg::KW'(1);
        end else if (r_sig_bits > KMax) begin
            k_eff = KMax;
        end else begin
            k_eff = r_sig_bits;
        end

        if (i_kind) begin
            n_s1.sign = i_value_bits[63];
            bexp      = i_value_bits[62:52];
            mant_zero = (i_value_bits[51:0] == '0);
            n_s1.frac = {1'b1, i_value_bits[51:0], 11'b0};
            bias      = ifq_pkg::BiasDouble;
            ewidth    = ifq_pkg::EwDouble;
        end else begin
            n_s1.sign = i_value_bits[31];
            bexp      = {3'b0, i_value_bits[30:23]};
            mant_zero = (i_value_bits[22:0] == '0);
            n_s1.frac = {1'b1, i_value_bits[22:0], 40'b0};
            bias      = ifq_pkg::BiasSingle;
            ewidth    = ifq_pkg::EwSingle;
        end

        n_s1.zero  = (bexp == '0) && mant_zero;
        raw_wide   = {2'b0, bexp} - bias - {6'b0, k_eff} + 13'd1;
        n_s1.raw   = raw_wide[ifq_pkg::ExpW-1:0];
        n_s1.clamp = (r_exp_bits < ewidth);
        n_s1.lim   = n_s1.clamp ? (11'd1 << r_exp_bits[3:0]) - 11'd1 : '0;
        n_s1.shamt = ifq_pkg::ShiftW'(7'd64 - k_eff);
    end

    // Stage 2: range check and coarse shift.
    ifq_pkg::t_ranged n_s2;
    ifq_pkg::t_ranged r_s2;
    logic             r_v2;
    logic signed [ifq_pkg::ExpW-1:0] lim_s;

    always_comb begin
        lim_s         = $signed({1'b0, r_s1.lim});
        n_s2.sign     = r_s1.zero ? 1'b0 : r_s1.sign;
        n_s2.zero     = r_s1.zero;
        n_s2.ovf      = r_s1.clamp && ($signed(r_s1.raw) > lim_s);
        n_s2.unf      = r_s1.clamp && ($signed(r_s1.raw) < -lim_s);
        n_s2.coarse   = r_s1.frac >> {r_s1.shamt[5:3], 3'b0};
        n_s2.shamt    = r_s1.shamt;
        if (r_s1.zero) begin
            n_s2.exp = '0;
        end else if (n_s2.ovf) begin
            n_s2.exp = lim_s;
        end else if (n_s2.unf) begin
            n_s2.exp = -lim_s;
        end else begin
            n_s2.exp = r_s1.raw;
        end
    end

    // Stage 3: fine shift and select.
    logic [ifq_pkg::FracW-1:0] n_sig;
    logic                      r_v3;

    always_comb begin
        priority if (r_s2.zero) begin
            n_sig = '0;
        end else if (r_s2.ovf) begin
            n_sig = {ifq_pkg::FracW{1'b1}} >> r_s2.shamt;
        end else if (r_s2.unf) begin
            n_sig = ifq_pkg::FracW'(1);
        end else begin
            n_sig = r_s2.coarse >> r_s2.shamt[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1          <= n_s1;
        r_s2          <= n_s2;
        o_significand <= n_sig[MAX_SIGNIFICAND_BITS-1:0];
        o_exponent    <= $signed(r_s2.exp);
        o_is_zero     <= r_s2.zero;
        o_sign        <= r_s2.sign;
    end

    assign o_valid = r_v3;
    assign o_busy  = 1'b0;

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_zero |-> (o_significand == '0) && (o_exponent == '0) && !o_sign)
        else $error("zero result carries nonzero fields");

    a_nonzero_sig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_zero |-> (o_significand != '0))
        else $error("nonzero input gave an empty significand");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##3 o_valid)
        else $error("transfer did not produce a result three cycles later");

    a_exp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_exponent <= 12'sd1024) && (o_exponent >= -12'sd1086))
        else $error("exponent out of range");

endmodule
